// ----- src/stbs_pkg.sv -----
package stbs_pkg;

  // Default number of table entries.
  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  // Fixed field widths of the item channels.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned HIGH_W  = 11;

  // Command codes of an input item.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Probe sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_DONE
  } state_t;

  // Outcome of one search, handed from the search core to the output stage.
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } result_t;

endpackage

// ----- src/sorted_table_binary_search_unit.sv -----
// Sorted-table binary search unit.
// Input channel (in_valid / in_stall): a transfer with command = load writes
// value into table entry load_index (ignored beyond the table) and gives no
// result. A transfer with command = search looks for key value in the
// inclusive range search_low..search_high; a negative or inverted range is
// empty, and search_high is clipped to the last table entry.
// Output channel (out_valid / out_stall): one transfer per search carrying
// found and position (position is 0 when not found).
// A load is written into the table at its input transfer. A search runs
// the probe loop: S_PROBE reads the table entry at the midpoint of the range
// through the registered read port, and S_COMPARE compares it with the key
// and halves the range, until a hit or an empty range leads to S_DONE. One
// item is worked on at a time; in_stall is high while a search is in
// progress, and the next input transfer can come at the earliest in the
// cycle after the result leaves the core.
// The result sits in an output register, so the next item is accepted while
// a result waits on out_stall; a finished search holds in the core until
// that register is free.
// Reset clears the control state and the output valid. The table is not
// cleared: entries must be loaded before a search probes them.
module sorted_table_binary_search_unit #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [stbs_pkg::INDEX_W-1:0]       load_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  logic [stbs_pkg::INDEX_W-1:0]       search_low,
  input  logic signed [stbs_pkg::HIGH_W-1:0] search_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [stbs_pkg::INDEX_W-1:0]       position
);
  import stbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = ((AW > INDEX_W) ? AW : INDEX_W) + 2;

  logic                 in_xfer;
  logic                 core_idle;
  logic                 load_ok;
  logic                 wr_en;
  logic                 start;
  logic signed [CW-1:0] start_lo;
  logic signed [CW-1:0] hi_ext;
  logic signed [CW-1:0] start_hi;
  logic                 res_valid;
  logic                 res_take;
  result_t              res;

  // Input transfers are taken only while no search is running.
  assign in_stall = !core_idle;
  assign in_xfer  = in_valid && !in_stall;

  // Load decode: entries beyond the table are dropped.
  assign load_ok = ({{(CW - INDEX_W){1'b0}}, load_index} < CW'(TABLE_DEPTH));
  assign wr_en   = in_xfer && (command == CMD_LOAD) && load_ok;
  assign start   = in_xfer && (command == CMD_SEARCH);

  // Range setup: negative high means empty, high is clipped to the table.
  assign start_lo = $signed({{(CW - INDEX_W){1'b0}}, search_low});
  assign hi_ext   = $signed({{(CW - INDEX_W){1'b0}}, search_high[INDEX_W-1:0]});
  always_comb begin
    if (search_high[HIGH_W-1]) begin
      start_hi = '1;
    end else if (hi_ext > $signed(CW'(TABLE_DEPTH - 1))) begin
      start_hi = $signed(CW'(TABLE_DEPTH - 1));
    end else begin
      start_hi = hi_ext;
    end
  end

  stbs_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (AW'(load_index)),
    .wr_data  (value),
    .start    (start),
    .start_key(value),
    .start_lo (start_lo),
    .start_hi (start_hi),
    .idle     (core_idle),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // Output register: refilled whenever it is empty or being drained.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_take) begin
      found    <= res.found;
      position <= res.position;
    end
  end

endmodule

// ----- src/stbs_core.sv -----
module stbs_core #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  parameter int unsigned CW          = ((AW > stbs_pkg::INDEX_W) ? AW : stbs_pkg::INDEX_W) + 2
) (
  input  logic                              clk,
  input  logic                              rst,
  // Table write port, used by load transfers.
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [stbs_pkg::VALUE_W-1:0]      wr_data,
  // Search start, with an already clamped inclusive range.
  input  logic                              start,
  input  logic signed [stbs_pkg::VALUE_W-1:0] start_key,
  input  logic signed [CW-1:0]              start_lo,
  input  logic signed [CW-1:0]              start_hi,
  output logic                              idle,
  // Search result handoff.
  output logic                              res_valid,
  input  logic                              res_take,
  output stbs_pkg::result_t                 res
);
  import stbs_pkg::*;

  logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data;
  logic               rd_en;

  state_t state, state_next;

  logic signed [CW-1:0]      lo, lo_next;
  logic signed [CW-1:0]      hi, hi_next;
  logic signed [CW-1:0]      probe, probe_next;
  logic signed [VALUE_W-1:0] key, key_next;
  logic                      found, found_next;

  logic signed [CW-1:0] span;
  logic signed [CW-1:0] mid;
  logic                 range_empty;
  logic                 hit;
  logic                 entry_above;

  // Table memory: one write port for loads, one registered read port for probes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[probe_next[AW-1:0]];
    end
  end

  // Midpoint of the current range and the outcome of the last probe.
  assign span        = hi - lo;
  assign mid         = lo + (span >>> 1);
  assign range_empty = (lo > hi);
  assign hit         = ($signed(rd_data) == key);
  assign entry_above = ($signed(rd_data) > key);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = range_empty ? S_DONE : S_COMPARE;
      end
      S_COMPARE: begin
        state_next = hit ? S_DONE : S_PROBE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates and memory read enable.
  always_comb begin
    lo_next    = lo;
    hi_next    = hi;
    probe_next = probe;
    key_next   = key;
    found_next = found;
    rd_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          lo_next    = start_lo;
          hi_next    = start_hi;
          key_next   = start_key;
          found_next = 1'b0;
        end
      end
      S_PROBE: begin
        probe_next = mid;
        rd_en      = !range_empty;
      end
      S_COMPARE: begin
        if (hit) begin
          found_next = 1'b1;
        end else if (entry_above) begin
          hi_next = probe - CW'(1);
        end else begin
          lo_next = probe + CW'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer state and search registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    lo    <= lo_next;
    hi    <= hi_next;
    probe <= probe_next;
    key   <= key_next;
    found <= found_next;
  end

  // Result presentation.
  assign idle         = (state == S_IDLE);
  assign res_valid    = (state == S_DONE);
  assign res.found    = found;
  assign res.position = found ? probe[INDEX_W-1:0] : '0;

endmodule

// ----- verif/bsearch_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the binary search unit, keeps its own copy of the
// table and predicts the outcome of every search transfer.
module bsearch_checker #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                command,
  input  logic [stbs_pkg::INDEX_W-1:0]        load_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] value,
  input  logic [stbs_pkg::INDEX_W-1:0]        search_low,
  input  logic signed [stbs_pkg::HIGH_W-1:0]  search_high,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                found,
  input  logic [stbs_pkg::INDEX_W-1:0]        position,
  output int                                  mismatches,
  output int                                  pending
);

  import stbs_pkg::*;

  // Shadow copy of the table contents.
  logic signed [VALUE_W-1:0] entry_mem [TABLE_DEPTH];

  // Search outcomes still owed by the block, oldest first.
  result_t expected_results [$];

  initial mismatches = 0;
  initial pending = 0;

  // Halving search over the shadow table. The upper bound is clipped to the
  // last entry, and a negative upper bound leaves the range empty.
  function automatic result_t lookup_key(input logic signed [VALUE_W-1:0] key,
                                         input logic [INDEX_W-1:0] lo_idx,
                                         input logic signed [HIGH_W-1:0] hi_idx);
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    result_t res;
    lo = int'(lo_idx);
    hi = int'(hi_idx);
    res = '0;
    done = 1'b0;
    if (hi > int'(TABLE_DEPTH) - 1) hi = int'(TABLE_DEPTH) - 1;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_mem[mid] == key) begin
        res.found = 1'b1;
        res.position = mid[INDEX_W-1:0];
        done = 1'b1;
      end else if (entry_mem[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Results are compared before the input transfer of the same edge is
  // taken in; a search can never complete in the cycle it is accepted.
  always @(posedge clk) begin : monitor
    result_t exp_res;
    if (rst) begin
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no search pending: found=%0b position=%0d",
                                    found, position));
        end else begin
          exp_res = expected_results.pop_front();
          if (found !== exp_res.found)
            report_mismatch($sformatf("found is %0b, expected %0b", found, exp_res.found));
          if (position !== exp_res.position)
            report_mismatch($sformatf("position is %0d, expected %0d",
                                      position, exp_res.position));
        end
      end
      if (in_valid && !in_stall) begin
        if (command == CMD_LOAD) begin
          if (load_index < TABLE_DEPTH) entry_mem[load_index] = value;
        end else begin
          expected_results.push_back(lookup_key(value, search_low, search_high));
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- verif/tb_sorted_table_binary_search_unit.sv -----
`timescale 1ns / 100ps

module tb_sorted_table_binary_search_unit;

  import stbs_pkg::*;

  localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DIRECTED_ITEMS = 21;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic signed [VALUE_W-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
  localparam logic signed [HIGH_W-1:0] MOST_NEGATIVE_HIGH = 11'sh400;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       command = CMD_LOAD;
  logic [INDEX_W-1:0]         load_index = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic [INDEX_W-1:0]         search_low = '0;
  logic signed [HIGH_W-1:0]   search_high = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       found;
  logic [INDEX_W-1:0]         position;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  // Table contents as the stimulus sees them, used to pick keys and to keep
  // every probed range inside loaded entries.
  logic signed [VALUE_W-1:0] shadow_val [DEPTH];
  bit                        shadow_written [DEPTH];

  sorted_table_binary_search_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .load_index (load_index),
    .value      (value),
    .search_low (search_low),
    .search_high(search_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position)
  );

  bsearch_checker #(
    .TABLE_DEPTH(DEPTH)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .load_index (load_index),
    .value      (value),
    .search_low (search_low),
    .search_high(search_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item after a random gap and return at the edge of its transfer.
  // Valid stays high when the next item follows with no gap.
  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val,
                           input logic [INDEX_W-1:0] lo,
                           input logic signed [HIGH_W-1:0] hi);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    load_index  <= idx;
    value       <= val;
    search_low  <= lo;
    search_high <= hi;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
    if (items_sent % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // A load carries random search fields so that their bits toggle too.
  task automatic load_entry(input int idx, input logic signed [VALUE_W-1:0] val);
    send_item(CMD_LOAD, idx[INDEX_W-1:0], val, INDEX_W'($urandom_range(0, 1023)),
              HIGH_W'($urandom_range(0, 2047)));
    shadow_val[idx] = val;
    shadow_written[idx] = 1'b1;
  endtask

  task automatic search_key(input logic signed [VALUE_W-1:0] key,
                            input logic [INDEX_W-1:0] lo,
                            input logic signed [HIGH_W-1:0] hi);
    send_item(CMD_SEARCH, INDEX_W'($urandom_range(0, 1023)), key, lo, hi);
  endtask

  // Last index of the stretch of loaded entries that starts at lo.
  function automatic int run_end(input int lo);
    int e;
    e = lo;
    while (e < int'(DEPTH) - 1 && shadow_written[e + 1]) e++;
    return e;
  endfunction

  // Load an ascending run of entries, with an occasional stray load that
  // may break the order elsewhere, then search it a number of times.
  task automatic fill_and_probe();
    int                        len;
    int                        base;
    int                        lo;
    int                        hi;
    int                        pick;
    int                        target;
    longint                    acc;
    longint                    step_max;
    logic signed [VALUE_W-1:0] key;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
    base = $urandom_range(0, DEPTH - len);
    case ($urandom_range(0, 2))
      0: acc = longint'(MIN_WORD);
      1: acc = longint'($signed($urandom));
      default: acc = longint'(MAX_WORD) - longint'(len) * 4;
    endcase
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 1000;
      2: step_max = 64'd1 << 24;
      default: step_max = (64'd1 << 32) / longint'(len);
    endcase
    for (int i = 0; i < len; i++) begin
      load_entry(base + i, acc[VALUE_W-1:0]);
      acc += longint'($urandom_range(0, int'(step_max > 64'h7FFF_FFFF ? 64'h7FFF_FFFF
                                                                       : step_max)));
      if (acc > longint'(MAX_WORD)) acc = longint'(MAX_WORD);
      if ($urandom_range(0, 19) == 0) load_entry($urandom_range(0, DEPTH - 1), $urandom);
    end
    repeat ($urandom_range(4, 20)) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Inverted or negative range: nothing is read.
        lo = $urandom_range(0, DEPTH - 1);
        hi = int'($urandom_range(0, lo + 1023)) - 1024;
        search_key($urandom, INDEX_W'(lo), HIGH_W'(hi));
      end else begin
        lo = (pick < 50) ? base : base + $urandom_range(0, len - 1);
        hi = (pick < 50) ? base + len - 1 : $urandom_range(lo, run_end(lo));
        target = $urandom_range(lo, hi);
        case ($urandom_range(0, 4))
          0, 1, 2: key = shadow_val[target];
          3: key = shadow_val[target] + ($urandom_range(0, 1) ? 1 : -1);
          default: key = $urandom;
        endcase
        search_key(key, INDEX_W'(lo), HIGH_W'(hi));
      end
    end
  endtask

  // Result side: random stalls per transfer, stretches without stalls, and
  // two long hold-offs that back the block up into its input.
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      if (taken == 40 || taken == 150)
        gap = HOLD_OFF_CYCLES;
      else
        gap = recv_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
      taken++;
      if (taken % 50 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: a small table with the extreme words and a duplicate, plus
    // the top entry of the index space.
    load_entry(0, MIN_WORD);
    load_entry(1, -1000);
    load_entry(2, -1);
    load_entry(3, 0);
    load_entry(4, 0);
    load_entry(5, 5);
    load_entry(6, 77777);
    load_entry(7, MAX_WORD);
    load_entry(DEPTH - 1, 42);

    // Hits at both ends, in the middle and on the duplicate; misses.
    search_key(MIN_WORD, 0, 7);
    search_key(MAX_WORD, 0, 7);
    search_key(5, 0, 7);
    search_key(0, 0, 7);
    search_key(6, 0, 7);
    search_key(77777, 6, 7);
    search_key(3, 3, 3);
    search_key(42, INDEX_W'(DEPTH - 1), HIGH_W'(DEPTH - 1));

    // Empty ranges: inverted, high of -1, most negative high, top low.
    search_key(-1, 5, 4);
    search_key(0, 0, -1);
    search_key(0, 0, MOST_NEGATIVE_HIGH);
    search_key(42, INDEX_W'(DEPTH - 1), 0);

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) fill_and_probe();
    in_valid <= 1'b0;

    // Drain every owed result, then allow for stray output.
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
